// ----- rtl/core/ccls_pkg.sv -----
// Package for the lock cycle sequencer: payload structs, command, event and step codes.
// It holds the burst descriptor that passes from the front end to the back end.
// It has no dependencies.
package ccls_pkg;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] event_code;
        logic       water_high;
        logic       left_moving;
        logic       right_moving;
    } t_in;

    typedef struct packed {
        logic       door_side;
        logic [3:0] command;
        logic [1:0] mode_report;
        logic [2:0] step_now;
        logic       last;
    } t_out;

    localparam int unsigned BURST_MAX = 4;
    localparam int unsigned IDX_W     = $clog2(BURST_MAX);
    localparam int unsigned CFG_IDX_W = 2;

    // input kinds
    localparam logic [1:0] K_EVENT  = 2'd0;
    localparam logic [1:0] K_START  = 2'd1;
    localparam logic [1:0] K_HALT   = 2'd2;
    localparam logic [1:0] K_RESUME = 2'd3;

    // plant events
    localparam logic [2:0] E_CLOSED     = 3'd0;
    localparam logic [2:0] E_STOPPED    = 3'd1;
    localparam logic [2:0] E_OPENED     = 3'd2;
    localparam logic [2:0] E_LEVEL_LOW  = 3'd3;
    localparam logic [2:0] E_ABOVE_V2   = 3'd4;
    localparam logic [2:0] E_ABOVE_V3   = 3'd5;
    localparam logic [2:0] E_LEVEL_HIGH = 3'd6;

    // door commands
    localparam logic [3:0] C_NONE         = 4'd0;
    localparam logic [3:0] C_CLOSE        = 4'd1;
    localparam logic [3:0] C_OPEN         = 4'd2;
    localparam logic [3:0] C_LOCK         = 4'd3;
    localparam logic [3:0] C_STOP         = 4'd4;
    localparam logic [3:0] C_BOTTOM_VALVE = 4'd5;
    localparam logic [3:0] C_MIDDLE_VALVE = 4'd6;
    localparam logic [3:0] C_TOP_VALVE    = 4'd7;
    localparam logic [3:0] C_CLOSE_VALVES = 4'd8;

    // mode reports
    localparam logic [1:0] M_UNCHANGED = 2'd0;
    localparam logic [1:0] M_IDLE      = 2'd1;
    localparam logic [1:0] M_STAY      = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] R_LEFT_LOCK  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] R_RIGHT_LOCK = CFG_IDX_W'(1);

    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    typedef enum logic [2:0] {
        S_CLOSE_L = 3'd0,
        S_CLOSE_R = 3'd1,
        S_OPEN_L  = 3'd2,
        S_OPEN_R  = 3'd3,
        S_BOT_L   = 3'd4,
        S_BOT_R   = 3'd5,
        S_MID_R   = 3'd6,
        S_TOP_R   = 3'd7
    } t_step;

    typedef struct packed {
        logic [BURST_MAX-1:0]      side;
        logic [BURST_MAX-1:0][3:0] cmd;
        logic [IDX_W-1:0]          len_m1;
        logic [1:0]                mode;
        logic [2:0]                step;
    } t_burst;

    function automatic logic entry_side(input t_step step);
        logic s;
        case (step)
            S_CLOSE_L, S_OPEN_L, S_BOT_L: s = SIDE_LEFT;
            default:                      s = SIDE_RIGHT;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] entry_cmd(input t_step step);
        logic [3:0] c;
        case (step)
            S_CLOSE_L, S_CLOSE_R: c = C_CLOSE;
            S_OPEN_L, S_OPEN_R:   c = C_OPEN;
            S_BOT_L, S_BOT_R:     c = C_BOTTOM_VALVE;
            S_MID_R:              c = C_MIDDLE_VALVE;
            default:              c = C_TOP_VALVE;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/ccls_front.sv -----
// Front end of the lock cycle sequencer: takes input transactions, holds the sub-step
// and the lock registers, and builds one burst descriptor per transaction.
// Depends on ccls_pkg.
module ccls_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  ccls_pkg::t_in                   i_in,
    input  logic                            i_full,
    output logic                            o_push,
    output ccls_pkg::t_burst                o_burst,
    input  logic                            i_cfg_valid,
    input  logic [ccls_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic                            i_cfg_data
);
    import ccls_pkg::*;

    t_step r_sub_step;
    t_step n_sub_step;
    logic  r_left_lock;
    logic  r_right_lock;

    logic [BURST_MAX-1:0]      side;
    logic [BURST_MAX-1:0][3:0] cmd;
    logic [IDX_W:0]            cnt;
    logic [1:0]                mode;
    logic                      dside;
    logic                      has_lock;

    always_comb begin
        side       = '0;
        cmd        = '0;
        cnt        = '0;
        mode       = M_UNCHANGED;
        n_sub_step = r_sub_step;
        dside      = r_sub_step[0];
        has_lock   = dside ? r_right_lock : r_left_lock;
        case (i_in.kind)
            K_EVENT: begin
                case (r_sub_step)
                    S_CLOSE_L, S_CLOSE_R: begin
                        if (i_in.event_code == E_CLOSED || i_in.event_code == E_STOPPED) begin
                            if (has_lock) begin
                                side[cnt[IDX_W-1:0]] = dside;
                                cmd[cnt[IDX_W-1:0]]  = C_LOCK;
                                cnt                  = cnt + 1'b1;
                            end
                            if (i_in.event_code == E_CLOSED) begin
                                n_sub_step = dside ? S_BOT_L : S_BOT_R;
                            end
                            side[cnt[IDX_W-1:0]] = entry_side(n_sub_step);
                            cmd[cnt[IDX_W-1:0]]  = entry_cmd(n_sub_step);
                            cnt                  = cnt + 1'b1;
                        end
                    end
                    S_OPEN_L, S_OPEN_R: begin
                        if (i_in.event_code == E_OPENED) begin
                            mode = M_IDLE;
                        end else if (i_in.event_code == E_STOPPED) begin
                            mode    = M_STAY;
                            side[0] = entry_side(r_sub_step);
                            cmd[0]  = entry_cmd(r_sub_step);
                            cnt     = (IDX_W+1)'(1);
                        end
                    end
                    S_BOT_L: begin
                        if (i_in.event_code == E_LEVEL_LOW) begin
                            n_sub_step = S_OPEN_L;
                            side[0]    = SIDE_LEFT;
                            cmd[0]     = C_CLOSE_VALVES;
                            side[1]    = entry_side(S_OPEN_L);
                            cmd[1]     = entry_cmd(S_OPEN_L);
                            cnt        = (IDX_W+1)'(2);
                        end
                    end
                    S_BOT_R: begin
                        if (i_in.event_code == E_ABOVE_V2) begin
                            n_sub_step = S_MID_R;
                            side[0]    = entry_side(S_MID_R);
                            cmd[0]     = entry_cmd(S_MID_R);
                            cnt        = (IDX_W+1)'(1);
                        end
                    end
                    S_MID_R: begin
                        if (i_in.event_code == E_ABOVE_V3) begin
                            n_sub_step = S_TOP_R;
                            side[0]    = entry_side(S_TOP_R);
                            cmd[0]     = entry_cmd(S_TOP_R);
                            cnt        = (IDX_W+1)'(1);
                        end
                    end
                    default: begin
                        if (i_in.event_code == E_LEVEL_HIGH) begin
                            n_sub_step = S_OPEN_R;
                            side[0]    = SIDE_RIGHT;
                            cmd[0]     = C_CLOSE_VALVES;
                            side[1]    = entry_side(S_OPEN_R);
                            cmd[1]     = entry_cmd(S_OPEN_R);
                            cnt        = (IDX_W+1)'(2);
                        end
                    end
                endcase
            end
            K_START: begin
                n_sub_step = i_in.water_high ? S_CLOSE_R : S_CLOSE_L;
                side[0]    = entry_side(n_sub_step);
                cmd[0]     = entry_cmd(n_sub_step);
                cnt        = (IDX_W+1)'(1);
            end
            K_HALT: begin
                side[0] = SIDE_LEFT;
                cmd[0]  = C_CLOSE_VALVES;
                side[1] = SIDE_RIGHT;
                cmd[1]  = C_CLOSE_VALVES;
                cnt     = (IDX_W+1)'(2);
                if (i_in.left_moving) begin
                    side[cnt[IDX_W-1:0]] = SIDE_LEFT;
                    cmd[cnt[IDX_W-1:0]]  = C_STOP;
                    cnt                  = cnt + 1'b1;
                end
                if (i_in.right_moving) begin
                    side[cnt[IDX_W-1:0]] = SIDE_RIGHT;
                    cmd[cnt[IDX_W-1:0]]  = C_STOP;
                    cnt                  = cnt + 1'b1;
                end
            end
            default: begin
                side[0] = entry_side(r_sub_step);
                cmd[0]  = entry_cmd(r_sub_step);
                cnt     = (IDX_W+1)'(1);
            end
        endcase
        // nothing to command: one empty result
        if (cnt == '0) begin
            cnt = (IDX_W+1)'(1);
        end
    end

    assign o_push         = i_in_valid && !i_full;
    assign o_burst.side   = side;
    assign o_burst.cmd    = cmd;
    assign o_burst.len_m1 = IDX_W'(cnt - 1'b1);
    assign o_burst.mode   = mode;
    assign o_burst.step   = n_sub_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_step   <= S_CLOSE_L;
            r_left_lock  <= 1'b0;
            r_right_lock <= 1'b0;
        end else begin
            if (o_push) begin
                r_sub_step <= n_sub_step;
            end
            if (i_cfg_valid && i_cfg_index == R_LEFT_LOCK) begin
                r_left_lock <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == R_RIGHT_LOCK) begin
                r_right_lock <= i_cfg_data;
            end
        end
    end

endmodule

// ----- rtl/core/ccls_queue.sv -----
// Two-entry queue of burst descriptors between the front end and the back end.
// Depends on ccls_pkg.
module ccls_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ccls_pkg::t_burst i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output ccls_pkg::t_burst o_head
);
    import ccls_pkg::*;

    t_burst     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/core/ccls_back.sv -----
// Back end of the lock cycle sequencer: walks the head burst one command per cycle,
// unless the output is stalled, into the output register and pops the descriptor after its last command.
// Depends on ccls_pkg.
module ccls_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  ccls_pkg::t_burst i_q_head,
    output logic             o_q_pop,
    output logic             o_out_valid,
    output ccls_pkg::t_out   o_out,
    input  logic             i_out_stall
);
    import ccls_pkg::*;

    logic                r_out_valid;
    t_out                r_out;
    logic [IDX_W-1:0]    r_idx;
    logic                advance;
    logic                load;
    logic                at_end;

    assign advance = !r_out_valid || !i_out_stall;
    assign load    = advance && i_q_valid;
    assign at_end  = (r_idx == i_q_head.len_m1);
    assign o_q_pop = load && at_end;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.door_side   <= i_q_head.side[r_idx];
            r_out.command     <= i_q_head.cmd[r_idx];
            r_out.mode_report <= i_q_head.mode;
            r_out.step_now    <= i_q_head.step;
            r_out.last        <= at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= i_q_valid;
            end
            if (load) begin
                r_idx <= at_end ? '0 : r_idx + 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/canal_lock_cycle_sequencer_unit.sv -----
// Canal lock cycle sequencer: top level tying front end, burst queue and back end.
// Depends on ccls_pkg, ccls_front, ccls_queue, ccls_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) takes one transaction per cycle
//   while o_in_stall is low: an event, a start, a halt or a resume. Each gives a burst
//   of one to four door commands on the output channel (o_out_valid / i_out_stall /
//   o_out), one per cycle while i_out_stall is low, the final one flagged by last.
//   A burst's first command passes through the burst queue and then the output register.
//   Throughput: one command per cycle out of the back end unless the output stalls;
//   the front end accepts one input per cycle while the two-entry burst queue has room.
//   Configuration (i_cfg_valid / o_cfg_ready, always ready) writes the left and right
//   lock flags; write only while the block is idle.
//   Reset (i_rst_n low, synchronous) sets the sub-step to close-left, clears both
//   lock flags and empties the queue and the output register.
//   When the receiver stalls, the output holds its command; the queue fills and then
//   o_in_stall rises until a slot frees.
module canal_lock_cycle_sequencer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ccls_pkg::t_in                   i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ccls_pkg::t_out                  o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ccls_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic                            i_cfg_data
);
    import ccls_pkg::*;

    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_valid;
    t_burst burst;
    t_burst q_head;

    assign o_in_stall  = q_full;
    assign o_cfg_ready = 1'b1;

    ccls_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .i_full      (q_full),
        .o_push      (push),
        .o_burst     (burst),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    ccls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (burst),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    ccls_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_q_pop     (pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

// ----- sim/canal_lock_cycle_sequencer_unit_test.sv -----
// Self-checking testbench for canal_lock_cycle_sequencer_unit: a directed pass, then random
// start/event/halt/resume traffic under changing lock settings and back-pressure.
// Depends on ccls_pkg and the canal_lock_cycle_sequencer_unit RTL.
module canal_lock_cycle_sequencer_unit_test;
    import ccls_pkg::*;

    localparam logic [2:0]           EV_OTHER      = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B  = CFG_IDX_W'(3);
    localparam int                   SETTLE_CYCLES = 4;
    localparam int                   DRAIN_CYCLES  = 10;
    localparam int                   HOLD_CYCLES   = 40;
    localparam int                   SEG_ITEMS     = 85;
    localparam int                   LIMIT_TIME    = 3600000;

    class lock_scoreboard;
        t_step      step;
        logic       left_lock;
        logic       right_lock;
        t_out       expected_q[$];
        logic       burst_side[$];
        logic [3:0] burst_cmd[$];
        int         errors;
        int         n_in;
        int         n_out;

        function new();
            step       = S_CLOSE_L;
            left_lock  = 1'b0;
            right_lock = 1'b0;
            errors     = 0;
            n_in       = 0;
            n_out      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic d);
            if (idx == R_LEFT_LOCK) begin
                left_lock = d;
            end else if (idx == R_RIGHT_LOCK) begin
                right_lock = d;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void add_cmd(logic side, logic [3:0] c);
            burst_side.push_back(side);
            burst_cmd.push_back(c);
        endfunction

        function void add_entry();
            case (step)
                S_CLOSE_L: add_cmd(SIDE_LEFT, C_CLOSE);
                S_CLOSE_R: add_cmd(SIDE_RIGHT, C_CLOSE);
                S_OPEN_L:  add_cmd(SIDE_LEFT, C_OPEN);
                S_OPEN_R:  add_cmd(SIDE_RIGHT, C_OPEN);
                S_BOT_L:   add_cmd(SIDE_LEFT, C_BOTTOM_VALVE);
                S_BOT_R:   add_cmd(SIDE_RIGHT, C_BOTTOM_VALVE);
                S_MID_R:   add_cmd(SIDE_RIGHT, C_MIDDLE_VALVE);
                default:   add_cmd(SIDE_RIGHT, C_TOP_VALVE);
            endcase
        endfunction

        function void add_lock(logic side);
            if (side ? right_lock : left_lock) add_cmd(side, C_LOCK);
        endfunction

        function logic [1:0] apply_event(logic [2:0] ev);
            logic [1:0] mode;
            logic       side;
            mode = M_UNCHANGED;
            side = (step == S_CLOSE_R);
            case (step)
                S_CLOSE_L, S_CLOSE_R: begin
                    if (ev == E_CLOSED) begin
                        add_lock(side);
                        step = side ? S_BOT_L : S_BOT_R;
                        add_entry();
                    end else if (ev == E_STOPPED) begin
                        add_lock(side);
                        add_entry();
                    end
                end
                S_OPEN_L, S_OPEN_R: begin
                    if (ev == E_OPENED) begin
                        mode = M_IDLE;
                    end else if (ev == E_STOPPED) begin
                        mode = M_STAY;
                        add_entry();
                    end
                end
                S_BOT_L: begin
                    if (ev == E_LEVEL_LOW) begin
                        add_cmd(SIDE_LEFT, C_CLOSE_VALVES);
                        step = S_OPEN_L;
                        add_entry();
                    end
                end
                S_BOT_R: begin
                    if (ev == E_ABOVE_V2) begin
                        step = S_MID_R;
                        add_entry();
                    end
                end
                S_MID_R: begin
                    if (ev == E_ABOVE_V3) begin
                        step = S_TOP_R;
                        add_entry();
                    end
                end
                default: begin
                    if (ev == E_LEVEL_HIGH) begin
                        add_cmd(SIDE_RIGHT, C_CLOSE_VALVES);
                        step = S_OPEN_R;
                        add_entry();
                    end
                end
            endcase
            return mode;
        endfunction

        function void note_input(t_in it);
            logic [1:0] mode;
            t_out       r;
            burst_side.delete();
            burst_cmd.delete();
            mode = M_UNCHANGED;
            n_in++;
            case (it.kind)
                K_EVENT: mode = apply_event(it.event_code);
                K_START: begin
                    step = it.water_high ? S_CLOSE_R : S_CLOSE_L;
                    add_entry();
                end
                K_HALT: begin
                    add_cmd(SIDE_LEFT, C_CLOSE_VALVES);
                    add_cmd(SIDE_RIGHT, C_CLOSE_VALVES);
                    if (it.left_moving) add_cmd(SIDE_LEFT, C_STOP);
                    if (it.right_moving) add_cmd(SIDE_RIGHT, C_STOP);
                end
                default: add_entry();
            endcase
            if (burst_cmd.size() == 0) add_cmd(SIDE_LEFT, C_NONE);
            foreach (burst_cmd[k]) begin
                r.door_side   = burst_side[k];
                r.command     = burst_cmd[k];
                r.mode_report = mode;
                r.step_now    = step;
                r.last        = (k == burst_cmd.size() - 1);
                expected_q.push_back(r);
            end
        endfunction

        function void cmp(string field, logic [3:0] want, logic [3:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: door_side %0d command %0d",
                       got.door_side, got.command);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            n_out++;
            cmp("door_side", 4'(want.door_side), 4'(got.door_side));
            cmp("command", want.command, got.command);
            cmp("mode_report", 4'(want.mode_report), 4'(got.mode_report));
            cmp("step_now", 4'(want.step_now), 4'(got.step_now));
            cmp("last", 4'(want.last), 4'(got.last));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in                  i_in;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out                 o_out;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic                 i_cfg_data;

    lock_scoreboard sb = new();
    int             snd_idle;
    int             rcv_idle;
    int             n_settings;
    bit             hold_req;

    canal_lock_cycle_sequencer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_TIME);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic t_in make_item(logic [1:0] k, logic [2:0] ev, logic wh, logic lm,
                                      logic rm);
        t_in it;
        it.kind         = k;
        it.event_code   = ev;
        it.water_high   = wh;
        it.left_moving  = lm;
        it.right_moving = rm;
        return it;
    endfunction

    // mostly the event that moves the current step on, with random filler bits
    function automatic t_in next_item();
        logic [$bits(t_in)-1:0] raw;
        t_in                    it;
        int                     r;
        raw = 8'($urandom_range(255));
        it  = raw;
        r   = $urandom_range(99);
        if (r < 70) begin
            it.kind = K_EVENT;
            case (sb.step)
                S_CLOSE_L, S_CLOSE_R:
                    it.event_code = ($urandom_range(4) == 0) ? E_STOPPED : E_CLOSED;
                S_OPEN_L, S_OPEN_R: begin
                    r = $urandom_range(9);
                    if (r < 3) begin
                        it.kind = K_START;
                    end else begin
                        it.event_code = (r < 5) ? E_STOPPED : E_OPENED;
                    end
                end
                S_BOT_L: it.event_code = E_LEVEL_LOW;
                S_BOT_R: it.event_code = E_ABOVE_V2;
                S_MID_R: it.event_code = E_ABOVE_V3;
                default: it.event_code = E_LEVEL_HIGH;
            endcase
        end else if (r < 80) begin
            it.kind = K_START;
        end else if (r < 88) begin
            it.kind = K_HALT;
        end else if (r < 94) begin
            it.kind = K_RESUME;
        end
        return it;
    endfunction

    task automatic send_item(t_in it);
        while ($urandom_range(99) < snd_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, d);
    endtask

    task automatic set_locks(logic left_l, logic right_l);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(R_LEFT_LOCK, left_l);
        write_reg(R_RIGHT_LOCK, right_l);
        write_reg(n_settings[0] ? REG_UNUSED_B : REG_UNUSED_A, 1'($urandom_range(1)));
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && !i_out_stall) sb.check_result(o_out);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < rcv_idle);
            end
        end
    end

    initial begin : stimulus
        t_in  first_q[$];
        t_in  second_q[$];
        logic seg_locks[6][2];
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= 1'b0;
        snd_idle    = 22;
        rcv_idle    = 61;
        n_settings  = 0;
        hold_req    = 1'b0;
        seg_locks   = '{'{0, 1}, '{1, 0}, '{1, 1}, '{0, 0}, '{1, 1}, '{0, 1}};

        // no locks: walk both cycles, a halt and a resume
        first_q.push_back(make_item(K_RESUME, E_CLOSED, 0, 0, 0));
        first_q.push_back(make_item(K_EVENT, E_CLOSED, 1, 1, 1));
        first_q.push_back(make_item(K_EVENT, EV_OTHER, 0, 0, 0));
        first_q.push_back(make_item(K_EVENT, E_ABOVE_V2, 0, 0, 0));
        first_q.push_back(make_item(K_EVENT, E_ABOVE_V3, 0, 0, 0));
        first_q.push_back(make_item(K_EVENT, E_LEVEL_HIGH, 0, 0, 0));
        first_q.push_back(make_item(K_EVENT, E_STOPPED, 0, 0, 0));
        first_q.push_back(make_item(K_EVENT, E_OPENED, 0, 0, 0));
        first_q.push_back(make_item(K_START, EV_OTHER, 1, 0, 0));
        first_q.push_back(make_item(K_EVENT, E_STOPPED, 0, 0, 0));
        first_q.push_back(make_item(K_EVENT, E_CLOSED, 0, 0, 0));
        first_q.push_back(make_item(K_EVENT, E_LEVEL_LOW, 0, 0, 0));
        first_q.push_back(make_item(K_HALT, 3'd0, 0, 1, 1));
        first_q.push_back(make_item(K_EVENT, E_OPENED, 0, 0, 0));
        first_q.push_back(make_item(K_START, 3'd0, 0, 0, 0));
        // both locks fitted
        second_q.push_back(make_item(K_EVENT, E_STOPPED, 0, 0, 0));
        second_q.push_back(make_item(K_EVENT, E_CLOSED, 0, 0, 0));
        second_q.push_back(make_item(K_START, 3'd0, 1, 0, 0));
        second_q.push_back(make_item(K_EVENT, E_STOPPED, 0, 0, 0));
        second_q.push_back(make_item(K_EVENT, E_CLOSED, 0, 0, 0));
        second_q.push_back(make_item(K_HALT, 3'd0, 0, 1, 0));
        second_q.push_back(make_item(K_HALT, 3'd0, 0, 0, 1));
        second_q.push_back(make_item(K_HALT, 3'd0, 0, 0, 0));
        second_q.push_back(make_item(K_EVENT, EV_OTHER, 0, 0, 0));
        second_q.push_back(make_item(K_RESUME, 3'd0, 0, 0, 0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (first_q[i]) send_item(first_q[i]);
        set_locks(1'b1, 1'b1);
        foreach (second_q[i]) send_item(second_q[i]);

        for (int seg = 0; seg < 6; seg++) begin
            if (seg < 2) begin
                snd_idle = 22;
                rcv_idle = 61;
            end else if (seg < 4) begin
                snd_idle = 61;
                rcv_idle = 22;
            end else begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            set_locks(seg_locks[seg][0], seg_locks[seg][1]);
            if (seg == 4) hold_req = 1'b1;
            repeat (SEG_ITEMS) send_item(next_item());
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d transactions driven, %0d results checked, %0d lock settings",
                 sb.n_in, sb.n_out, n_settings);
        $display("covered: every step and input kind, three idle profiles, one long hold-off");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/ccls_pkg.sv
rtl/core/ccls_front.sv
rtl/core/ccls_queue.sv
rtl/core/ccls_back.sv
rtl/core/canal_lock_cycle_sequencer_unit.sv
sim/canal_lock_cycle_sequencer_unit_test.sv
